// ===== rtl/ros_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ros_pkg: shared types and constants of the rank ordered symbol list
// Holds the transaction payload structs, the request codes, the reset value
// of the rescaling period and the control group broadcast to the cells.
// ----------------------------------------------------------------------------
package ros_pkg;

	localparam logic REQ_HIT    = 1'b0;
	localparam logic REQ_APPEND = 1'b1;

	localparam int unsigned PERIOD_W     = 16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4096;
	localparam int unsigned SYM_W        = 8;

	typedef struct packed {
		logic             req_type;
		logic [SYM_W-1:0] symbol;
		logic [2:0]       slot;
	} in_t;

	typedef struct packed {
		logic [63:0] list_word;
		logic [3:0]  fill_count;
		logic [2:0]  new_slot;
	} out_t;

	typedef struct packed {
		logic             en;
		logic             req_type;
		logic             rescale;
		logic [SYM_W-1:0] symbol;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/ros_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ros_cell: one slot of the rank ordered symbol list
// Holds one symbol and its hit count, takes its lower neighbor's entry when
// a promoted entry bubbles past, and rescales its count on request.
// ----------------------------------------------------------------------------
module ros_cell #(
	parameter int COUNT_BITS = 13,
	parameter int IDX_W      = 3,
	parameter int IDX        = 0,
	parameter bit IS_LAST    = 1'b0
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire ros_pkg::cell_ctrl_t          ctrl,
	input  wire  [IDX_W-1:0]                  pos,
	input  wire  [COUNT_BITS-1:0]             c_new,
	input  wire  [COUNT_BITS-1:0]             nbr_cnt,
	input  wire  [ros_pkg::SYM_W-1:0]         nbr_sym,
	input  wire                               reach_in,
	input  wire                               reach_below,
	input  wire                               found_in,
	output logic                              reach_out,
	output logic                              found_out,
	output logic                              hot,
	output logic [COUNT_BITS-1:0]             cnt_o,
	output logic [ros_pkg::SYM_W-1:0]         sym_o,
	output logic [ros_pkg::SYM_W-1:0]         sym_d
);

	logic [COUNT_BITS-1:0]     cnt_q;
	logic [ros_pkg::SYM_W-1:0] sym_q;
	logic [COUNT_BITS-1:0]     cnt_upd;
	logic [COUNT_BITS-1:0]     cnt_d;
	logic                      is_pos;
	logic                      cand;
	logic                      sel;

	function automatic logic [COUNT_BITS-1:0] lead_one(input logic [COUNT_BITS:0] v);
		logic [COUNT_BITS-1:0] r;
		r = '0;
		for (int i = 0; i <= COUNT_BITS; i++) begin
			if (v[i]) begin
				r = COUNT_BITS'(i);
			end
		end
		return r;
	endfunction

	assign is_pos    = (pos == IDX_W'(IDX));
	assign reach_out = is_pos || (reach_in && (c_new > cnt_q));
	assign cand      = (cnt_q == '0) || IS_LAST;
	assign sel       = cand && !found_in;
	assign found_out = found_in || cand;
	assign cnt_o     = cnt_q;
	assign sym_o     = sym_q;

	always_comb begin
		cnt_upd = cnt_q;
		sym_d   = sym_q;
		hot     = 1'b0;
		case (ctrl.req_type)
			ros_pkg::REQ_HIT: begin
				if (reach_out && reach_below) begin
					cnt_upd = nbr_cnt;
					sym_d   = nbr_sym;
				end else if (reach_out) begin
					cnt_upd = c_new;
					hot     = 1'b1;
					if (!is_pos) begin
						sym_d = ctrl.symbol;
					end
				end
			end
			ros_pkg::REQ_APPEND: begin
				if (sel) begin
					cnt_upd = COUNT_BITS'(1);
					sym_d   = ctrl.symbol;
					hot     = 1'b1;
				end else if (found_in) begin
					sym_d = '0;
				end
			end
			default: begin
				cnt_upd = cnt_q;
			end
		endcase
		cnt_d = ctrl.rescale ? lead_one({1'b0, cnt_upd} + 1'b1) : cnt_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sym_q <= '0;
		end else if (ctrl.en) begin
			cnt_q <= cnt_d;
			sym_q <= sym_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rank_ordered_symbol_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rank_ordered_symbol_list: frequency count self-organizing byte list
// The input channel (in_valid, in_stall, in_data) carries one request per
// transaction: a hit on a slot or an append of a new symbol. The output
// channel (out_valid, out_stall, out_data) returns one transaction per
// request with the packed list, the fill count and the symbol's new slot.
// The result is registered before it shows on the output. One request is
// taken every cycle while in_stall is low; the figure is set by the row of
// slot cells, which compare, shift and rescale combinationally.
// When the receiver stalls, one more result is held in a skid register and
// in_stall then rises until the output drains.
// cfg_we and cfg_wdata write the rescaling period; write it only while the
// block is idle.
// Reset clears all symbols and counts, the fill and operation counters, and
// sets the period to 4096.
// ----------------------------------------------------------------------------
module rank_ordered_symbol_list #(
	parameter int SLOTS      = 8,
	parameter int COUNT_BITS = 13
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire ros_pkg::in_t                in_data,
	output logic                             out_valid,
	input  wire                              out_stall,
	output ros_pkg::out_t                    out_data,
	input  wire                              cfg_we,
	input  wire  [ros_pkg::PERIOD_W-1:0]     cfg_wdata
);

	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HELD_W = $clog2(SLOTS + 1);

	logic [ros_pkg::PERIOD_W-1:0] period_q;
	logic [ros_pkg::PERIOD_W-1:0] op_q;
	logic [ros_pkg::PERIOD_W-1:0] op_next;
	logic [HELD_W-1:0]            held_q;
	logic [HELD_W-1:0]            held_d;

	logic                         acc;
	logic                         take;
	logic                         rescale;
	logic [IDX_W-1:0]             pos;
	logic [COUNT_BITS-1:0]        cnt_at_pos;
	logic [COUNT_BITS-1:0]        c_new;
	ros_pkg::cell_ctrl_t          ctrl;

	logic [COUNT_BITS-1:0]        cnt_a [SLOTS];
	logic [ros_pkg::SYM_W-1:0]    sym_a [SLOTS];
	logic [ros_pkg::SYM_W-1:0]    sym_d_a [SLOTS];
	logic [SLOTS:0]               reach;
	logic [SLOTS-1:0]             reach_dn;
	logic [SLOTS:0]               found;
	logic [SLOTS-1:0]             hot;
	logic [IDX_W-1:0]             dest;
	logic [63:0]                  word;
	ros_pkg::out_t                res;

	logic                         out_valid_q;
	ros_pkg::out_t                out_q;
	logic                         skid_valid_q;
	ros_pkg::out_t                skid_q;

	assign in_stall  = skid_valid_q;
	assign acc       = in_valid && !skid_valid_q;
	assign take      = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign op_next = op_q + 1'b1;
	assign rescale = (op_next >= period_q);

	always_comb begin
		if (32'(in_data.slot) >= 32'(SLOTS)) begin
			pos = IDX_W'(SLOTS - 1);
		end else begin
			pos = IDX_W'(in_data.slot);
		end
	end

	assign cnt_at_pos = cnt_a[pos];
	assign c_new      = (cnt_at_pos == '1) ? cnt_at_pos : cnt_at_pos + 1'b1;

	always_comb begin
		ctrl.en       = acc;
		ctrl.req_type = in_data.req_type;
		ctrl.rescale  = rescale;
		ctrl.symbol   = in_data.symbol;
	end

	assign reach[SLOTS] = 1'b0;
	assign found[0]     = 1'b0;

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		logic [COUNT_BITS-1:0]     nbr_cnt;
		logic [ros_pkg::SYM_W-1:0] nbr_sym;

		if (k == 0) begin : g_first
			assign nbr_cnt     = '0;
			assign nbr_sym     = '0;
			assign reach_dn[k] = 1'b0;
		end else begin : g_rest
			assign nbr_cnt     = cnt_a[k-1];
			assign nbr_sym     = sym_a[k-1];
			assign reach_dn[k] = reach[k-1];
		end

		ros_cell #(
			.COUNT_BITS (COUNT_BITS),
			.IDX_W      (IDX_W),
			.IDX        (k),
			.IS_LAST    (k == SLOTS - 1)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.pos         (pos),
			.c_new       (c_new),
			.nbr_cnt     (nbr_cnt),
			.nbr_sym     (nbr_sym),
			.reach_in    (reach[k+1]),
			.reach_below (reach_dn[k]),
			.found_in    (found[k]),
			.reach_out   (reach[k]),
			.found_out   (found[k+1]),
			.hot         (hot[k]),
			.cnt_o       (cnt_a[k]),
			.sym_o       (sym_a[k]),
			.sym_d       (sym_d_a[k])
		);
	end

	for (genvar b = 0; b < 8; b++) begin : g_word
		if (b < SLOTS) begin : g_used
			assign word[8*b +: 8] = sym_d_a[b];
		end else begin : g_pad
			assign word[8*b +: 8] = '0;
		end
	end

	always_comb begin
		dest = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (hot[k]) begin
				dest = dest | IDX_W'(k);
			end
		end
	end

	always_comb begin
		held_d = held_q;
		if ((in_data.req_type == ros_pkg::REQ_APPEND) && (held_q < HELD_W'(SLOTS))) begin
			held_d = held_q + 1'b1;
		end
	end

	always_comb begin
		res.list_word  = word;
		res.fill_count = 4'(held_d);
		res.new_slot   = 3'(dest);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= ros_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= '0;
			held_q <= '0;
		end else if (acc) begin
			op_q   <= rescale ? '0 : op_next;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	a_dest_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> $onehot(hot))
		else $error("request did not land in exactly one slot");

	a_append_target: assert property (@(posedge clk) disable iff (!arst_n)
		found[SLOTS])
		else $error("append found no target slot");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a transaction while the output is empty");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(SLOTS))
		else $error("fill count exceeds the number of slots");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rank ordered symbol list
// A short directed sequence covers empty-slot hits, bubbling, list overflow
// and fill saturation. Random hit and append traffic then runs under several
// rescaling periods, including zero, one and the maximum, and a run of hits
// on slot 0 builds up one count. Both channels idle and stall at random.
// A scoreboard predicts every result and checks each output transaction in
// order.
// ----------------------------------------------------------------------------
module tb;

	localparam int IDLE_LIMIT = 4000;

	class symbol_list_scoreboard;
		logic [7:0]  sym_at[8];
		logic [12:0] hits_at[8];
		logic [15:0] op_tally;
		logic [15:0] period;
		logic [3:0]  fill;
		ros_pkg::out_t expected_results[$];
		int          mismatch_count;

		function new();
			foreach (sym_at[k]) begin
				sym_at[k] = '0;
				hits_at[k] = '0;
			end
			op_tally = '0;
			period = ros_pkg::PERIOD_RESET;
			fill = '0;
			mismatch_count = 0;
		endfunction

		function void note_request(ros_pkg::in_t req);
			int cur;
			int k;
			int lead;
			logic [12:0] moved_hits;
			logic [13:0] v;
			ros_pkg::out_t res;
			if (req.req_type == ros_pkg::REQ_HIT) begin
				cur = int'(req.slot);
				if (hits_at[cur] != '1)
					hits_at[cur]++;
				while (cur > 0 && hits_at[cur] > hits_at[cur-1]) begin
					moved_hits = hits_at[cur];
					hits_at[cur] = hits_at[cur-1];
					hits_at[cur-1] = moved_hits;
					sym_at[cur] = sym_at[cur-1];
					sym_at[cur-1] = req.symbol;
					cur--;
				end
			end else begin
				cur = 0;
				while (cur < 7 && hits_at[cur] != 0)
					cur++;
				hits_at[cur] = 13'd1;
				sym_at[cur] = req.symbol;
				for (k = cur + 1; k < 8; k++)
					sym_at[k] = '0;
				if (fill < 8)
					fill++;
			end
			op_tally++;
			if (op_tally >= period) begin
				for (k = 0; k < 8; k++) begin
					v = {1'b0, hits_at[k]} + 14'd1;
					lead = 0;
					while (v > 1) begin
						v = v >> 1;
						lead++;
					end
					hits_at[k] = 13'(lead);
				end
				op_tally = '0;
			end
			for (k = 0; k < 8; k++)
				res.list_word[8*k +: 8] = sym_at[k];
			res.fill_count = fill;
			res.new_slot = 3'(cur);
			expected_results.push_back(res);
		endfunction

		function void check_result(ros_pkg::out_t got);
			ros_pkg::out_t want;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: list %h fill %0d slot %0d",
						got.list_word, got.fill_count, got.new_slot);
			end else begin
				want = expected_results.pop_front();
				if (got.list_word !== want.list_word ||
						got.fill_count !== want.fill_count ||
						got.new_slot !== want.new_slot) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: expected list %h fill %0d slot %0d,",
							" got list %h fill %0d slot %0d"},
							want.list_word, want.fill_count, want.new_slot,
							got.list_word, got.fill_count, got.new_slot);
				end
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	ros_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	ros_pkg::out_t out_data;
	logic          cfg_we = 1'b0;
	logic [15:0]   cfg_wdata = '0;

	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	int quiet_cycles = 0;

	symbol_list_scoreboard lists = new();

	always #4 clk = ~clk;

	rank_ordered_symbol_list uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic ros_pkg::in_t random_request();
		ros_pkg::in_t req;
		req.req_type = ($urandom_range(0, 99) < 25) ? ros_pkg::REQ_APPEND : ros_pkg::REQ_HIT;
		req.slot = 3'($urandom_range(0, 7));
		if (lists.fill > 0 && $urandom_range(0, 9) < 8)
			req.slot = 3'($urandom_range(0, lists.fill - 1));
		req.symbol = 8'($urandom_range(0, 255));
		if (req.req_type == ros_pkg::REQ_HIT && $urandom_range(0, 9) < 7)
			req.symbol = lists.sym_at[req.slot];
		return req;
	endfunction

	task automatic send_request(input ros_pkg::in_t req);
		int gap;
		gap = sender_idles ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall !== 1'b0);
		lists.note_request(req);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (lists.expected_results.size() != 0);
	endtask

	task automatic write_period(input logic [15:0] value);
		wait_all_results();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		lists.period = value;
	endtask

	initial begin
		int stall_left;
		logic next_stall;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0)
				lists.check_result(out_data);
			next_stall = 1'b0;
			if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else if (receiver_idles && $urandom_range(0, 99) < 15) begin
				stall_left = pick_gap();
				next_stall = 1'b1;
			end
			out_stall <= next_stall;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int phase_period[6];
		int p;
		int k;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hits on an empty list first, then appends past the last slot, then hits on the full list.
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'hAA, 3'd0});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'h55, 3'd7});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'hFF, 3'd7});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'h00, 3'd5});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'hFF, 3'd2});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'h80, 3'd1});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'h01, 3'd6});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'h7F, 3'd3});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'hC3, 3'd4});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'h3C, 3'd0});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'h96, 3'd7});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_APPEND, 8'h69, 3'd7});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'h12, 3'd4});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'h34, 3'd3});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'hFF, 3'd7});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'h00, 3'd7});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'h5A, 3'd6});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'hA5, 3'd5});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'h0F, 3'd1});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'hF0, 3'd2});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'h00, 3'd0});
		send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'h00, 3'd0});

		phase_period = '{1, 0, 2, 9, 0, 4096};
		phase_period[4] = $urandom_range(3, 200);
		for (p = 0; p < 6; p++) begin
			write_period(16'(phase_period[p]));
			sender_idles = (p != 3);
			receiver_idles = (p != 3);
			for (k = 0; k < 200; k++) begin
				if (p == 0 && k == 100)
					wait_all_results();
				send_request(random_request());
			end
		end

		// With the longest period, repeated hits on slot 0 keep raising its count.
		write_period(16'hFFFF);
		for (k = 0; k < 100; k++)
			send_request(ros_pkg::in_t'{ros_pkg::REQ_HIT, 8'($urandom_range(0, 255)), 3'd0});
		for (k = 0; k < 30; k++)
			send_request(random_request());

		wait_all_results();
		repeat (5) @(posedge clk);
		if (lists.mismatch_count == 0 && lists.expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/ros_pkg.sv
rtl/ros_cell.sv
rtl/rank_ordered_symbol_list.sv
bench/tb.sv
